### hw/rtl/jts_pkg.sv
`default_nettype none

package jts_pkg;

    localparam int CELL_W  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int DIM_W   = 7;
    localparam int COEF_W  = 16;
    localparam int ACC_W   = 52;
    localparam int QUEUE_DEPTH = 8;

    localparam logic [2:0] REG_INTERIOR_X   = 3'd0;
    localparam logic [2:0] REG_INTERIOR_Y   = 3'd1;
    localparam logic [2:0] REG_INTERIOR_Z   = 3'd2;
    localparam logic [2:0] REG_COEF_X       = 3'd3;
    localparam logic [2:0] REG_COEF_Y       = 3'd4;
    localparam logic [2:0] REG_COEF_Z       = 3'd5;
    localparam logic [2:0] REG_STOP_THRESH  = 3'd6;

    typedef struct packed {
        logic [DIM_W-1:0]  interior_x;
        logic [DIM_W-1:0]  interior_y;
        logic [DIM_W-1:0]  interior_z;
        logic [COEF_W-1:0] coef_x;
        logic [COEF_W-1:0] coef_y;
        logic [COEF_W-1:0] coef_z;
        logic [CELL_W-1:0] stop_threshold;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic [CELL_W-1:0]  west;
        logic [CELL_W-1:0]  east;
        logic [CELL_W-1:0]  north;
        logic [CELL_W-1:0]  south;
        logic [CELL_W-1:0]  centre;
        logic [CELL_W-1:0]  down;
        logic [CELL_W-1:0]  up;
    } fetch_t;

    typedef struct packed {
        logic [CELL_W-1:0] new_value;
        logic [CELL_W-1:0] max_change;
        logic              converged;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/jts_front.sv
`default_nettype none

module jts_front
    import jts_pkg::*;
#(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              accept,
    input  wire logic [CELL_W-1:0] cell_value,
    output logic                   produce,
    output fetch_t                 fetch
);

    localparam int MAXD   = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                            : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
    localparam int DW     = $clog2(MAXD + 3);
    localparam int STRIDE = MAX_X + 2;
    localparam int PLANE  = STRIDE * (MAX_Y + 2);
    localparam int DEPTH  = 2 * PLANE;
    localparam int AW     = $clog2(DEPTH);

    function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [11:0] e;
        logic [11:0] r;
        e = 12'(v);
        if (e == 12'd0)
            r = 12'd1;
        else if (e > 12'(hi))
            r = 12'(hi);
        else
            r = e;
        return DW'(r);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic par, input logic [DW-1:0] xx,
                                              input logic [DW-1:0] yy);
        return AW'(int'(par) * PLANE + int'(yy) * STRIDE + int'(xx));
    endfunction

    logic [DW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [DW-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [DW-1:0] nx, ny, nz, x, y, z;
    logic          pc, pz, first, last;

    logic [CELL_W-1:0] bank0 [DEPTH];
    logic [CELL_W-1:0] bank1 [DEPTH];
    logic [CELL_W-1:0] bank2 [DEPTH];

    logic              valid_reg, first_reg, last_reg;
    logic [CELL_W-1:0] up_reg;
    logic [CELL_W-1:0] rd_w, rd_e, rd_c, rd_n, rd_s, rd_d;

    always_comb
    begin
        nx = clamp_dim(cfg.interior_x, MAX_X);
        ny = clamp_dim(cfg.interior_y, MAX_Y);
        nz = clamp_dim(cfg.interior_z, MAX_Z);
        // drop a position that a smaller grid no longer holds
        x = (pos_x_reg >= nx + DW'(2)) ? '0 : pos_x_reg;
        y = (pos_y_reg >= ny + DW'(2)) ? '0 : pos_y_reg;
        z = (pos_z_reg >= nz + DW'(2)) ? '0 : pos_z_reg;
        pc = ~z[0];
        pz = z[0];
        produce = (x >= DW'(1)) && (x <= nx) && (y >= DW'(1)) && (y <= ny) && (z >= DW'(2));
        first = (x == DW'(1)) && (y == DW'(1)) && (z == DW'(2));
        last  = (x == nx) && (y == ny) && (z == nz + DW'(1));

        pos_x_next = x + DW'(1);
        pos_y_next = y;
        pos_z_next = z;
        if (pos_x_next >= nx + DW'(2))
        begin
            pos_x_next = '0;
            pos_y_next = y + DW'(1);
            if (pos_y_next >= ny + DW'(2))
            begin
                pos_y_next = '0;
                pos_z_next = z + DW'(1);
                if (pos_z_next >= nz + DW'(2))
                    pos_z_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept && produce;
            if (accept)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                pos_z_reg <= pos_z_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg <= first;
            last_reg  <= last;
            up_reg    <= cell_value;
        end
    end

    // three copies of the store, each written alike, give six read ports
    always_ff @(posedge clk)
    begin
        if (accept)
            bank0[addr_of(pz, x, y)] <= cell_value;
        if (accept && produce)
        begin
            rd_w <= bank0[addr_of(pc, x - DW'(1), y)];
            rd_e <= bank0[addr_of(pc, x + DW'(1), y)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            bank1[addr_of(pz, x, y)] <= cell_value;
        if (accept && produce)
        begin
            rd_c <= bank1[addr_of(pc, x, y)];
            rd_n <= bank1[addr_of(pc, x, y - DW'(1))];
        end
    end

    // the plane below shares parity with the incoming one: read before the write lands
    always_ff @(posedge clk)
    begin
        if (accept)
            bank2[addr_of(pz, x, y)] <= cell_value;
        if (accept && produce)
        begin
            rd_s <= bank2[addr_of(pc, x, y + DW'(1))];
            rd_d <= bank2[addr_of(pz, x, y)];
        end
    end

    always_comb
    begin
        fetch.valid  = valid_reg;
        fetch.first  = first_reg;
        fetch.last   = last_reg;
        fetch.west   = rd_w;
        fetch.east   = rd_e;
        fetch.north  = rd_n;
        fetch.south  = rd_s;
        fetch.centre = rd_c;
        fetch.down   = rd_d;
        fetch.up     = up_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/jts_back.sv
`default_nettype none

module jts_back
    import jts_pkg::*;
#(
    parameter int FRAC_BITS   = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire fetch_t fetch,
    output logic        push,
    output result_t     result
);

    localparam int NW = (VALUE_WIDTH > ACC_W) ? VALUE_WIDTH : ACC_W;
    localparam logic signed [NW:0] SAT_HI =
        (NW+1)'((65'sd1 <<< (VALUE_WIDTH - 1)) - 65'sd1);
    localparam logic signed [NW:0] SAT_LO = -SAT_HI - (NW+1)'(1);
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

    logic               v2_reg, v3_reg, v4_reg;
    logic               f2_reg, f3_reg, f4_reg;
    logic               l2_reg, l3_reg, l4_reg;
    logic signed [32:0] sx_reg, sy_reg, sz_reg;
    logic signed [CELL_W-1:0] old2_reg, old3_reg, old4_reg;
    logic signed [49:0] px_reg, py_reg, pz_reg;
    logic signed [NW:0] nv_reg;
    logic [CELL_W-1:0]  rmax_reg;

    logic signed [ACC_W-1:0] acc, shifted;
    logic signed [NW:0]      wide, nv;
    logic signed [NW+1:0]    d, mag;
    logic [CELL_W-1:0]       diff, base, newmax;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            rmax_reg <= '0;
        end
        else
        begin
            v2_reg <= fetch.valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (v4_reg)
                rmax_reg <= newmax;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg   <= 33'(signed'(fetch.west))  + 33'(signed'(fetch.east));
        sy_reg   <= 33'(signed'(fetch.north)) + 33'(signed'(fetch.south));
        sz_reg   <= 33'(signed'(fetch.down))  + 33'(signed'(fetch.up));
        old2_reg <= signed'(fetch.centre);
        f2_reg   <= fetch.first;
        l2_reg   <= fetch.last;

        px_reg   <= sx_reg * signed'({1'b0, cfg.coef_x});
        py_reg   <= sy_reg * signed'({1'b0, cfg.coef_y});
        pz_reg   <= sz_reg * signed'({1'b0, cfg.coef_z});
        old3_reg <= old2_reg;
        f3_reg   <= f2_reg;
        l3_reg   <= l2_reg;

        nv_reg   <= nv;
        old4_reg <= old3_reg;
        f4_reg   <= f3_reg;
        l4_reg   <= l3_reg;
    end

    always_comb
    begin
        acc = ACC_W'(px_reg) + ACC_W'(py_reg) + ACC_W'(pz_reg) + ROUND;
        shifted = acc >>> FRAC_BITS;
        wide = (NW+1)'(shifted);
        if (wide > SAT_HI)
            nv = SAT_HI;
        else if (wide < SAT_LO)
            nv = SAT_LO;
        else
            nv = wide;
    end

    always_comb
    begin
        d = (NW+2)'(old4_reg) - (NW+2)'(nv_reg);
        mag = (d < 0) ? -d : d;
        diff = (|mag[NW+1:CELL_W]) ? '1 : mag[CELL_W-1:0];
        // a new sweep starts its maximum afresh
        base = f4_reg ? '0 : rmax_reg;
        newmax = (diff > base) ? diff : base;

        push = v4_reg;
        result.new_value  = nv_reg[CELL_W-1:0];
        result.max_change = newmax;
        result.converged  = l4_reg && (newmax < cfg.stop_threshold);
        result.last       = l4_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/jts_queue.sv
`default_nettype none

module jts_queue
    import jts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    reserve,
    input  wire logic    push,
    input  wire result_t entry,
    input  wire logic    pop,
    output result_t      head,
    output logic         empty,
    output logic         full
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_t         store [QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   held_reg, held_next;
    logic            take;

    always_comb
    begin
        take = pop && !empty;
        count_next = count_reg + CW'(push) - CW'(take);
        // hold a place for every accepted cell that yields a result until it is popped
        held_next = held_reg + CW'(reserve) - CW'(take);
        empty = (count_reg == '0);
        full = (held_reg == CW'(QUEUE_DEPTH));
        head = store[rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            held_reg  <= held_next;
            if (push)
                wr_reg <= (wr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + AW'(1);
            if (take)
                rd_reg <= (rd_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_reg] <= entry;
    end

endmodule

`default_nettype wire

### hw/rtl/jacobi_3d_stencil_sweep_unit.sv
`default_nettype none

// One Jacobi sweep of a padded 3D grid, 7-point stencil. Push the padded grid,
// halo included, in raster order (x fastest); one cell is taken every cycle
// while full is low. Each interior result is queued, with the running maximum
// change of the sweep, once the cell above it is taken; the final interior cell
// carries last and the convergence flag. An eight-entry result queue sets how
// far pushes may run ahead of pops: full rises when eight results are pending
// or in flight. The plane store is written once per accepted cell and held in
// three copies to supply the centre and five neighbours in the same cycle.
// Configuration writes are always ready and belong between sweeps.
module jacobi_3d_stencil_sweep_unit
    import jts_pkg::*;
#(
    parameter int MAX_X       = 64,
    parameter int MAX_Y       = 64,
    parameter int MAX_Z       = 64,
    parameter int FRAC_BITS   = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CELL_W-1:0] cell_value,
    output logic                   empty,
    input  wire logic              pop,
    output logic [CELL_W-1:0]      new_value,
    output logic [CELL_W-1:0]      max_change,
    output logic                   converged,
    output logic                   last,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);

    cfg_t    cfg_reg;
    logic    accept, produce, bpush;
    fetch_t  fetch;
    result_t entry, head;

    assign cfg_ready = 1'b1;
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interior_x     <= DIM_W'(8);
            cfg_reg.interior_y     <= DIM_W'(8);
            cfg_reg.interior_z     <= DIM_W'(8);
            cfg_reg.coef_x         <= COEF_W'(10923);
            cfg_reg.coef_y         <= COEF_W'(10923);
            cfg_reg.coef_z         <= COEF_W'(10923);
            cfg_reg.stop_threshold <= CELL_W'(66);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INTERIOR_X:  cfg_reg.interior_x     <= cfg_data[DIM_W-1:0];
                REG_INTERIOR_Y:  cfg_reg.interior_y     <= cfg_data[DIM_W-1:0];
                REG_INTERIOR_Z:  cfg_reg.interior_z     <= cfg_data[DIM_W-1:0];
                REG_COEF_X:      cfg_reg.coef_x         <= cfg_data[COEF_W-1:0];
                REG_COEF_Y:      cfg_reg.coef_y         <= cfg_data[COEF_W-1:0];
                REG_COEF_Z:      cfg_reg.coef_z         <= cfg_data[COEF_W-1:0];
                REG_STOP_THRESH: cfg_reg.stop_threshold <= cfg_data;
                default:         ;
            endcase
        end
    end

    jts_front #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .cell_value (cell_value),
        .produce    (produce),
        .fetch      (fetch)
    );

    jts_back #(
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fetch  (fetch),
        .push   (bpush),
        .result (entry)
    );

    jts_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .reserve (accept && produce),
        .push    (bpush),
        .entry   (entry),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    assign new_value  = head.new_value;
    assign max_change = head.max_change;
    assign converged  = head.converged;
    assign last       = head.last;

endmodule

`default_nettype wire

### sim/jacobi_3d_stencil_sweep_unit_tb.sv
`default_nettype none

module jacobi_3d_stencil_sweep_unit_tb;
    import jts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX   = 64;
    localparam int ROW_PITCH  = GRID_MAX + 2;
    localparam int PLANE_CELLS = ROW_PITCH * ROW_PITCH;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 1650;

    typedef enum int { VAL_RANDOM, VAL_EXTREME, VAL_SMOOTH } value_mode_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [CELL_W-1:0] cell_value;
    logic              empty;
    logic              pop;
    logic [CELL_W-1:0] new_value;
    logic [CELL_W-1:0] max_change;
    logic              converged;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;

    jacobi_3d_stencil_sweep_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cell_value (cell_value),
        .empty      (empty),
        .pop        (pop),
        .new_value  (new_value),
        .max_change (max_change),
        .converged  (converged),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // shadow of the block's registers and state
    logic [DIM_W-1:0]  sh_nx, sh_ny, sh_nz;
    logic [COEF_W-1:0] sh_cx, sh_cy, sh_cz;
    logic [CELL_W-1:0] sh_thresh;
    logic [CELL_W-1:0] plane_mem [0:2*PLANE_CELLS-1];
    int unsigned       at_x, at_y, at_z;
    logic [CELL_W-1:0] sweep_max;

    result_t     pending_results[$];
    int          error_count;
    int unsigned cycle_count;
    int unsigned cells_sent;
    int unsigned results_seen;
    int unsigned sweeps_done;
    int          burst_left;
    int          smooth_base;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > GRID_MAX) ? GRID_MAX : int'(v);
    endfunction

    function automatic longint stored_cell(int unsigned x, int unsigned y, int unsigned p);
        return longint'($signed(plane_mem[p * PLANE_CELLS + y * ROW_PITCH + x]));
    endfunction

    // advance the stencil shadow by one accepted cell
    task automatic update_stencil(logic [CELL_W-1:0] cur);
        int unsigned nx, ny, nz, pc;
        longint      old, acc, nv, d;
        logic [CELL_W-1:0] diff, base;
        result_t     r;
        bit          is_first, is_last;
        nx = eff_dim(sh_nx);
        ny = eff_dim(sh_ny);
        nz = eff_dim(sh_nz);
        if (at_x >= nx + 2) at_x = 0;
        if (at_y >= ny + 2) at_y = 0;
        if (at_z >= nz + 2) at_z = 0;
        if (at_x >= 1 && at_x <= nx && at_y >= 1 && at_y <= ny && at_z >= 2)
        begin
            pc  = (at_z - 1) & 1;
            old = stored_cell(at_x, at_y, pc);
            acc = (stored_cell(at_x - 1, at_y, pc) + stored_cell(at_x + 1, at_y, pc))
                  * longint'(sh_cx)
                + (stored_cell(at_x, at_y - 1, pc) + stored_cell(at_x, at_y + 1, pc))
                  * longint'(sh_cy)
                + (stored_cell(at_x, at_y, at_z & 1) + longint'($signed(cur)))
                  * longint'(sh_cz);
            nv = (acc + 64'sd32768) >>> 16;
            if (nv > 64'sd2147483647) nv = 64'sd2147483647;
            if (nv < -64'sd2147483648) nv = -64'sd2147483648;
            d = old - nv;
            if (d < 0) d = -d;
            diff = (d > 64'sd4294967295) ? 32'hFFFF_FFFF : d[31:0];
            is_first = (at_x == 1 && at_y == 1 && at_z == 2);
            is_last  = (at_x == nx && at_y == ny && at_z == nz + 1);
            base = is_first ? '0 : sweep_max;
            sweep_max = (diff > base) ? diff : base;
            r.new_value  = nv[31:0];
            r.max_change = sweep_max;
            r.converged  = is_last && (sweep_max < sh_thresh);
            r.last       = is_last;
            pending_results.push_back(r);
        end
        plane_mem[(at_z & 1) * PLANE_CELLS + at_y * ROW_PITCH + at_x] = cur;
        at_x++;
        if (at_x >= nx + 2)
        begin
            at_x = 0;
            at_y++;
            if (at_y >= ny + 2)
            begin
                at_y = 0;
                at_z++;
                if (at_z >= nz + 2)
                begin
                    at_z = 0;
                    sweeps_done++;
                end
            end
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("Mismatch on %s: got %h, expected %h (result %0d)",
                 what, got, want, results_seen);
        error_count++;
    endtask

    // receiver: check each popped beat, stall on its own pattern
    int stall_mode;
    int stall_left;
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("Unexpected result beat %h", new_value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (new_value !== want.new_value)
                    report("new_value", new_value, want.new_value);
                if (max_change !== want.max_change)
                    report("max_change", max_change, want.max_change);
                if (converged !== want.converged)
                    report("converged", 32'(converged), 32'(want.converged));
                if (last !== want.last)
                    report("last", 32'(last), 32'(want.last));
            end
            results_seen++;
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
        endcase
    end

    // sender: one cell beat, bursts with random gaps
    task automatic send_cell(logic [CELL_W-1:0] v);
        int gap;
        cell_value <= v;
        push <= 1'b1;
        do @(posedge clk); while (full);
        update_stencil(v);
        cells_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // hold push through a burst boundary that has no gap
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INTERIOR_X:  sh_nx = data[DIM_W-1:0];
            REG_INTERIOR_Y:  sh_ny = data[DIM_W-1:0];
            REG_INTERIOR_Z:  sh_nz = data[DIM_W-1:0];
            REG_COEF_X:      sh_cx = data[COEF_W-1:0];
            REG_COEF_Y:      sh_cy = data[COEF_W-1:0];
            REG_COEF_Z:      sh_cz = data[COEF_W-1:0];
            REG_STOP_THRESH: sh_thresh = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // upper bits of the dimension writes carry noise that the block drops
    task automatic set_grid(int nx, int ny, int nz);
        write_reg(REG_INTERIOR_X,
                  32'({$urandom_range(0, 1) ? $urandom() : 32'd0, 7'd0} | nx));
        write_reg(REG_INTERIOR_Y,
                  32'({$urandom_range(0, 1) ? $urandom() : 32'd0, 7'd0} | ny));
        write_reg(REG_INTERIOR_Z,
                  32'({$urandom_range(0, 1) ? $urandom() : 32'd0, 7'd0} | nz));
    endtask

    task automatic set_coefs(int cx, int cy, int cz, logic [31:0] thresh);
        write_reg(REG_COEF_X, 32'({$urandom(), 16'd0} | cx));
        write_reg(REG_COEF_Y, 32'({$urandom(), 16'd0} | cy));
        write_reg(REG_COEF_Z, 32'({$urandom(), 16'd0} | cz));
        write_reg(REG_STOP_THRESH, thresh);
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CELL_W-1:0] pick_value(value_mode_t mode);
        case (mode)
            VAL_EXTREME:
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return $urandom();
                endcase
            VAL_SMOOTH:
                return smooth_base + $urandom_range(0, 8);
            default:
                return $urandom();
        endcase
    endfunction

    task automatic run_sweep(value_mode_t mode);
        smooth_base = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        do
            send_cell(pick_value(mode));
        while (at_x != 0 || at_y != 0 || at_z != 0);
        push <= 1'b0;
        drain();
    endtask

    // hold the reset grid for its first four planes, then leave the sweep open
    task automatic test_reset_defaults;
        repeat (400) send_cell(pick_value(VAL_RANDOM));
        push <= 1'b0;
        drain();
    endtask

    task automatic test_smallest_grid;
        set_grid(0, 0, 0);
        set_coefs(0, 0, 0, 32'd0);
        run_sweep(VAL_RANDOM);
        set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_sweep(VAL_EXTREME);
        set_grid(1, 1, 2);
        run_sweep(VAL_EXTREME);
    endtask

    task automatic test_widest_plane;
        set_grid(127, 1, 1);
        set_coefs(16'hFFFF, 0, 16'h8000, 32'd0);
        run_sweep(VAL_EXTREME);
    endtask

    task automatic test_convergence;
        set_grid(2, 2, 2);
        set_coefs(10923, 10923, 10923, 32'd100000);
        run_sweep(VAL_SMOOTH);
        set_coefs(10923, 10923, 10923, 32'd0);
        run_sweep(VAL_SMOOTH);
        set_coefs(0, 0, 0, 32'hFFFF_FFFF);
        run_sweep(VAL_SMOOTH);
    endtask

    // stop part-way through a sweep, then shrink the grid under the position
    task automatic test_shrink_midsweep;
        int n;
        set_grid(6, 5, 4);
        set_coefs(20000, 30000, 5000, 32'd1000);
        n = $urandom_range(100, 250);
        repeat (n) send_cell(pick_value(VAL_RANDOM));
        push <= 1'b0;
        drain();
        set_grid(2, 3, 2);
        run_sweep(VAL_RANDOM);
    endtask

    task automatic test_random_sweeps;
        value_mode_t mode;
        while (cells_sent < ITEM_TARGET)
        begin
            set_grid($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(1, 4));
            set_coefs($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535),
                      $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 4096));
            case ($urandom_range(0, 5))
                0: mode = VAL_EXTREME;
                1, 2: mode = VAL_SMOOTH;
                default: mode = VAL_RANDOM;
            endcase
            run_sweep(mode);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        cell_value  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        cycle_count = 0;
        cells_sent  = 0;
        results_seen = 0;
        sweeps_done = 0;
        burst_left  = 1;
        stall_mode  = 0;
        stall_left  = 0;
        sh_nx = 7'd8;
        sh_ny = 7'd8;
        sh_nz = 7'd8;
        sh_cx = 16'd10923;
        sh_cy = 16'd10923;
        sh_cz = 16'd10923;
        sh_thresh = 32'd66;
        at_x = 0;
        at_y = 0;
        at_z = 0;
        sweep_max = '0;
        foreach (plane_mem[i]) plane_mem[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_smallest_grid();
        test_widest_plane();
        test_convergence();
        test_shrink_midsweep();
        test_random_sweeps();

        $display("Pushed %0d cells over %0d sweeps and checked %0d results,",
                 cells_sent, sweeps_done, results_seen);
        $display("covering clamped and widest grids, coefficient extremes and a mid-sweep shrink");
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
